>>> sv/tcp_header_parser_unit_defines.svh
// ----------------------------------------------------------------------------
// tcp header parser assertion macros
// clocked assertion helpers shared by the checker
// ----------------------------------------------------------------------------
`ifndef TCP_HEADER_PARSER_UNIT_DEFINES_SVH
`define TCP_HEADER_PARSER_UNIT_DEFINES_SVH

// property checked at every rising clock edge outside reset
`define TCPHP_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked at every rising clock edge, reset included
`define TCPHP_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> sv/tcphp_pkg.sv
// ----------------------------------------------------------------------------
// tcp header parser package
// item codes, result codes and the descriptor passed from front to back
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tcphp_pkg;

   // fixed tcp header size in bytes
   localparam int HDR_MIN = 20;
   localparam int QUEUE_DEPTH_DEF = 2;
   localparam logic [7:0] DOFF_MASK = 8'hF0;
   localparam logic [7:0] NS_MASK = 8'h01;
   localparam logic [15:0] DOFF_POS = 16'd12;
   localparam int FLAG_BITS = 8;

   typedef enum logic [1:0] {
      FUNC_START = 2'd0,
      FUNC_BYTE  = 2'd1,
      FUNC_END   = 2'd2
   } func_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_OK_TRUNC  = 3'd1,
      ST_FRAGMENT  = 3'd2,
      ST_MALFORMED = 3'd3,
      ST_TRUNCATED = 3'd4
   } status_type;

   // input item payload, highest field first
   typedef struct packed {
      logic        pad;
      logic        ipv4_truncated;
      logic [15:0] payload_base;
      logic [12:0] fragment_offset;
      logic        more_fragments;
      logic [15:0] declared_length;
      logic [7:0]  seg_byte;
   } req_data_type;

   // classified end item on its way to the back end
   typedef struct packed {
      status_type           status;
      logic [16:0]          position;
      logic [5:0]           hlen;
      logic [15:0]          count;
      logic [19:0][7:0]     hdr;
   } desc_type;

   // result item payload, highest field first
   typedef struct packed {
      logic [15:0] payload_length;
      logic [15:0] urg_ptr;
      logic [15:0] checksum;
      logic [15:0] window;
      logic [8:0]  flags;
      logic [5:0]  hdr_len_bytes;
      logic [31:0] acknowledgment;
      logic [31:0] sequence_res;
      logic [15:0] dest_port;
      logic [15:0] src_port;
      logic [16:0] position;
   } rsp_data_type;

endpackage

>>> sv/tcphp_queue.sv
// ----------------------------------------------------------------------------
// tcp header parser descriptor queue
// small register fifo between the classifying front and the result back end
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tcphp_queue import tcphp_pkg::*; #(
   parameter int DEPTH = QUEUE_DEPTH_DEF,
   parameter int WIDTH = $bits(desc_type)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             not_empty,
   output logic [WIDTH-1:0] pop_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic             do_push, do_pop;

   assign full      = (fill_ff == CNT_W'(DEPTH));
   assign not_empty = (fill_ff != '0);
   assign pop_data  = entry_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> sv/tcphp_front.sv
// ----------------------------------------------------------------------------
// tcp header parser front end
// takes start, byte and end items, keeps the context and the first header
// bytes, and classifies each end item into a descriptor
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tcphp_front import tcphp_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [1:0]   req_tuser,
   input  req_data_type req_tdata,
   input  logic         q_full,
   output logic         q_push,
   output desc_type     q_data
);

   localparam logic [15:0] HDR_MIN16 = 16'(HDR_MIN);
   localparam logic [5:0]  HDR_MIN6  = 6'(HDR_MIN);

   logic [15:0]     count_ff, count_in;
   logic [15:0]     decl_ff, decl_in;
   logic            frag_ff, frag_in;
   logic [15:0]     base_ff, base_in;
   logic            trunc_ff, trunc_in;
   logic [19:0][7:0] hdr_ff;
   logic            accept;
   logic            hdr_write;
   logic [5:0]      hlen;
   logic [7:0]      doff_byte;
   logic [16:0]     pos_count;
   logic [16:0]     pos_doff;
   logic [16:0]     pos_hlen;

   assign req_tready = !q_full;
   assign accept     = req_tvalid && req_tready;

   // context and byte count update
   always_comb begin
      count_in  = count_ff;
      decl_in   = decl_ff;
      frag_in   = frag_ff;
      base_in   = base_ff;
      trunc_in  = trunc_ff;
      hdr_write = 1'b0;
      q_push    = 1'b0;
      if (accept) begin
         case (req_tuser)
            FUNC_START: begin
               decl_in  = req_tdata.declared_length;
               frag_in  = req_tdata.more_fragments || (req_tdata.fragment_offset != '0);
               base_in  = req_tdata.payload_base;
               trunc_in = req_tdata.ipv4_truncated;
               count_in = '0;
            end
            FUNC_BYTE: begin
               hdr_write = (count_ff < HDR_MIN16);
               if (count_ff != 16'hFFFF) begin
                  count_in = count_ff + 1'b1;
               end
            end
            FUNC_END: begin
               q_push = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         decl_ff  <= '0;
         frag_ff  <= 1'b0;
         base_ff  <= '0;
         trunc_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         decl_ff  <= decl_in;
         frag_ff  <= frag_in;
         base_ff  <= base_in;
         trunc_ff <= trunc_in;
      end
   end

   // header byte store, written at the running count
   always_ff @(posedge clock) begin
      if (hdr_write) begin
         hdr_ff[count_ff[4:0]] <= req_tdata.seg_byte;
      end
   end

   // header length from the data offset nibble of byte 12
   assign doff_byte = hdr_ff[12] & DOFF_MASK;
   assign hlen      = {doff_byte[7:4], 2'b00};
   assign pos_count = {1'b0, base_ff} + {1'b0, count_ff};
   assign pos_doff  = {1'b0, base_ff} + {1'b0, DOFF_POS};
   assign pos_hlen  = {1'b0, base_ff} + {11'd0, hlen};

   // classify the end item in check order
   always_comb begin
      q_data.hdr   = hdr_ff;
      q_data.count = count_ff;
      q_data.hlen  = hlen;
      if (frag_ff) begin
         q_data.status   = ST_FRAGMENT;
         q_data.position = {1'b0, base_ff};
      end else if (decl_ff < HDR_MIN16) begin
         q_data.status   = ST_MALFORMED;
         q_data.position = {1'b0, base_ff};
      end else if (count_ff < HDR_MIN16) begin
         q_data.status   = ST_TRUNCATED;
         q_data.position = pos_count;
      end else if ((hlen < HDR_MIN6) || ({10'd0, hlen} > decl_ff)) begin
         q_data.status   = ST_MALFORMED;
         q_data.position = pos_doff;
      end else if (count_ff < {10'd0, hlen}) begin
         q_data.status   = ST_TRUNCATED;
         q_data.position = pos_count;
      end else begin
         q_data.status   = trunc_ff ? ST_OK_TRUNC : ST_OK;
         q_data.position = pos_hlen;
      end
   end

endmodule

>>> sv/tcphp_back.sv
// ----------------------------------------------------------------------------
// tcp header parser back end
// turns a classified descriptor into the result item and holds it in the
// output register until the receiver takes it
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tcphp_back import tcphp_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         q_valid,
   input  desc_type     q_data,
   output logic         q_pop,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [2:0]   rsp_tuser,
   output rsp_data_type rsp_tdata
);

   logic         rsp_valid_ff, rsp_valid_in;
   status_type   status_ff;
   rsp_data_type data_ff, data_in;
   logic         load;
   logic         ok;
   logic [7:0]   ns_byte;

   assign load = q_valid && (!rsp_valid_ff || rsp_tready);
   assign q_pop = load;
   assign ok = (q_data.status == ST_OK) || (q_data.status == ST_OK_TRUNC);
   assign ns_byte = q_data.hdr[12] & NS_MASK;

   // field extraction, all fields but the position zero on any failure
   always_comb begin
      data_in = '0;
      data_in.position = q_data.position;
      if (ok) begin
         data_in.src_port       = {q_data.hdr[0], q_data.hdr[1]};
         data_in.dest_port      = {q_data.hdr[2], q_data.hdr[3]};
         data_in.sequence_res   = {q_data.hdr[4], q_data.hdr[5], q_data.hdr[6], q_data.hdr[7]};
         data_in.acknowledgment = {q_data.hdr[8], q_data.hdr[9], q_data.hdr[10],
                                   q_data.hdr[11]};
         data_in.hdr_len_bytes  = q_data.hlen;
         data_in.flags          = {ns_byte[0], q_data.hdr[13][FLAG_BITS-1:0]};
         data_in.window         = {q_data.hdr[14], q_data.hdr[15]};
         data_in.checksum       = {q_data.hdr[16], q_data.hdr[17]};
         data_in.urg_ptr        = {q_data.hdr[18], q_data.hdr[19]};
         data_in.payload_length = q_data.count - {10'd0, q_data.hlen};
      end
   end

   // output register handshake
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         status_ff <= q_data.status;
         data_ff   <= data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = status_ff;
   assign rsp_tdata  = data_ff;

endmodule

>>> sv/tcp_header_parser_unit.sv
// ----------------------------------------------------------------------------
// tcp header parser unit
// parses the fixed tcp header from a byte stream of the ipv4 payload
// ----------------------------------------------------------------------------
// usage
//   req channel: tuser selects the item kind (start with context, segment
//   byte, end of segment). a start item loads the packet context and clears
//   the byte count; byte items are counted and the first 20 are kept.
//   rsp channel: one result item per end item, status in tuser and the
//   parsed header fields in tdata; start and byte items give no result.
//   throughput: one item per cycle while the queue is not full, bytes and end items back to back.
//   path: an accepted end item is classified into the descriptor queue as
//   it is taken in, then loads the output register when that is free, and
//   is offered to the receiver from there.
//   stall: while rsp_tready is low the result holds; the queue absorbs
//   further end items and req_tready drops only when the queue is full.
//   reset: clears the context, byte count, queue and output valid; the
//   header byte store is not cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tcp_header_parser_unit import tcphp_pkg::*; #(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   // func
   input  logic [1:0]    req_tuser,
   // seg_byte, declared_length, more_fragments, fragment_offset,
   // payload_base, ipv4_truncated, zero pad
   input  logic [55:0]   req_tdata,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // status
   output logic [2:0]    rsp_tuser,
   // position, src_port, dest_port, sequence_res, acknowledgment,
   // hdr_len_bytes, flags, window, checksum, urg_ptr, payload_length
   output logic [191:0]  rsp_tdata
);

   localparam int DESC_W = $bits(desc_type);

   logic         q_full;
   logic         q_push;
   desc_type     q_push_data;
   logic         q_pop;
   logic         q_valid;
   desc_type     q_pop_data;
   rsp_data_type rsp_data;

   tcphp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_data_type'(req_tdata)),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_data     (q_push_data)
   );

   tcphp_queue #(
      .DEPTH (QUEUE_DEPTH),
      .WIDTH (DESC_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_valid),
      .pop_data  (q_pop_data)
   );

   tcphp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_data     (q_pop_data),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_data)
   );

   assign rsp_tdata = rsp_data;

endmodule

>>> sv/tcphp_checker.sv
// ----------------------------------------------------------------------------
// tcp header parser port checker
// watches the result channel of the top level over time
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "tcp_header_parser_unit_defines.svh"

module tcphp_checker import tcphp_pkg::*; (
   input logic         clock,
   input logic         reset,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [2:0]   rsp_tuser,
   input logic [191:0] rsp_tdata
);

   localparam logic [5:0] HDR_MIN_C = 6'(HDR_MIN);

   logic ok_status;
   logic rest_zero;
   logic hlen_ok;

   // result status and field views
   assign ok_status = (rsp_tuser == ST_OK) || (rsp_tuser == ST_OK_TRUNC);
   assign rest_zero = (rsp_tdata[191:17] == '0);
   assign hlen_ok   = (rsp_tdata[118:113] >= HDR_MIN_C);

   // a stalled result stays offered
   `TCPHP_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid, "result dropped")

   // no result in the cycle after a reset cycle
   `TCPHP_ASSERT_ALWAYS(a_rsp_reset, clock, reset |=> !rsp_tvalid, "result valid after reset")

   // failures carry only status and position
   `TCPHP_ASSERT(a_fail_zero, clock, reset, rsp_tvalid && !ok_status |-> rest_zero, "failure fields set")

   // a good header is at least the fixed size
   `TCPHP_ASSERT(a_ok_hlen, clock, reset, rsp_tvalid && ok_status |-> hlen_ok, "short good header")

endmodule

bind tcp_header_parser_unit tcphp_checker u_tcphp_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tuser  (rsp_tuser),
   .rsp_tdata  (rsp_tdata)
);
